// ===== rtl/core/sfdc_pkg.sv =====
// Shared types and constants for the sync-framed deframer with CRC-16 check.
// Used by the CRC unit and the top level; no dependencies.
package sfdc_pkg;

  // Parser phases, one per header, payload or check byte position.
  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LENH  = 3'd3;
  localparam logic [2:0] PH_LENL  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CRCH  = 3'd6;
  localparam logic [2:0] PH_CRCL  = 3'd7;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CRC      = 3'd1;
  localparam logic [2:0] ST_DRAIN_RD = 3'd2;
  localparam logic [2:0] ST_DRAIN_WR = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

  localparam logic [7:0]  SyncFirstReset   = 8'hAA;
  localparam logic [7:0]  SyncSecondReset  = 8'h55;
  localparam logic [6:0]  LengthLimitReset = 7'd64;

  // CRC-16-CCITT, MSB first, no final inversion.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last_step;
  } crc_stat_t;

endpackage

// ===== rtl/core/sync_frame_deframer_crc16_unit.sv =====
// Top level of the sync-framed deframer: header parser, sequencer and result register.
// Depends on sfdc_pkg, sfdc_crc_unit and sfdc_payload_buf.
//
// Usage: received bytes enter on rx_byte with in_valid; a transaction completes
// when in_valid is high and in_stall is low. The block hunts for the two sync
// bytes, reads a command byte and a big-endian 16-bit length, stores the
// payload and checks a big-endian CRC-16-CCITT over command, length and payload.
// Command, length and payload bytes are folded into the CRC by a bit-serial
// unit, so in_stall stays high after each of them until the unit has folded
// in all its bits. A low length byte that exceeds the limit drops the frame.
// Only a good frame produces results, one per payload byte, or one empty notice
// for a zero-length frame. They are read from the payload buffer, whose read
// port is registered, through a read state and a write state per result; an
// empty notice is loaded from the empty state. No input is taken until the
// frame is drained.
// While a result is valid and out_stall is high, the result register keeps
// its value and the drain waits. Configuration writes on cfg_valid/cfg_ready
// are always taken and must only be issued while the block is idle. Synchronous
// reset restores the default sync bytes and length limit and restarts the hunt.
module sync_frame_deframer_crc16_unit #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_cmd,
  output logic [6:0] frame_length,
  output logic [5:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       has_data,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sfdc_pkg::*;

  localparam int         AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] MaxLen = 7'(MAX_PAYLOAD);

  logic [2:0]  state;
  logic [2:0]  phase;
  logic [6:0]  fill_index;
  logic [7:0]  len_hi;
  logic [6:0]  length_reg;
  logic [7:0]  cmd_reg;
  logic [5:0]  drain_idx;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [6:0]  length_limit;

  logic        in_acc;
  logic        out_load;
  logic [15:0] len16;
  logic [6:0]  bound;
  logic        len_zero;
  logic        len_over;
  logic [6:0]  fill_inc;
  logic        drain_last;
  logic        wr_en;
  logic [7:0]  rd_data;
  logic [15:0] crc;
  crc_ctrl_t   crc_ctrl;
  crc_stat_t   crc_stat;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign len16    = {len_hi, rx_byte};
  assign bound    = (length_limit < MaxLen) ? length_limit : MaxLen;
  assign len_zero = (len16 == 16'd0);
  assign len_over = (len16 > {9'd0, bound});
  assign fill_inc = fill_index + 7'd1;

  assign drain_last = (({1'b0, drain_idx} + 7'd1) == length_reg);
  assign out_load   = ((state == ST_DRAIN_WR) || (state == ST_EMPTY)) &&
                      (!out_valid || !out_stall);

  assign crc_ctrl.init  = in_acc && (phase == PH_SYNC2) && (rx_byte == sync_second);
  assign crc_ctrl.start = in_acc && ((phase == PH_CMD) || (phase == PH_LENH) ||
                          (phase == PH_DATA) || ((phase == PH_LENL) && !len_over));
  assign crc_ctrl.data  = rx_byte;

  assign wr_en = in_acc && (phase == PH_DATA) && (fill_index < MaxLen);

  sfdc_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .stat (crc_stat),
    .crc  (crc)
  );

  sfdc_payload_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_index[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (state == ST_DRAIN_RD),
    .rd_addr (drain_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= SyncFirstReset;
      sync_second  <= SyncSecondReset;
      length_limit <= LengthLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:   sync_first   <= cfg_data;
        CFG_SYNC_SECOND:  sync_second  <= cfg_data;
        CFG_LENGTH_LIMIT: length_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_SYNC1;
      fill_index <= 7'd0;
      drain_idx  <= 6'd0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (phase)
              PH_SYNC1: begin
                if (rx_byte == sync_first) begin
                  phase <= PH_SYNC2;
                end
              end
              PH_SYNC2: begin
                if (rx_byte == sync_second) begin
                  phase      <= PH_CMD;
                  fill_index <= 7'd0;
                end else if (rx_byte != sync_first) begin
                  phase <= PH_SYNC1;
                end
              end
              PH_CMD: begin
                phase <= PH_LENH;
                state <= ST_CRC;
              end
              PH_LENH: begin
                phase <= PH_LENL;
                state <= ST_CRC;
              end
              PH_LENL: begin
                if (len_zero) begin
                  phase <= PH_CRCH;
                  state <= ST_CRC;
                end else if (len_over) begin
                  phase      <= PH_SYNC1;
                  fill_index <= 7'd0;
                end else begin
                  phase <= PH_DATA;
                  state <= ST_CRC;
                end
              end
              PH_DATA: begin
                fill_index <= fill_inc;
                state      <= ST_CRC;
                if (fill_inc >= length_reg) begin
                  phase <= PH_CRCH;
                end
              end
              PH_CRCH: begin
                if (rx_byte == crc[15:8]) begin
                  phase <= PH_CRCL;
                end else begin
                  phase      <= PH_SYNC1;
                  fill_index <= 7'd0;
                end
              end
              default: begin
                phase      <= PH_SYNC1;
                fill_index <= 7'd0;
                drain_idx  <= 6'd0;
                if (rx_byte == crc[7:0]) begin
                  state <= (length_reg == 7'd0) ? ST_EMPTY : ST_DRAIN_RD;
                end
              end
            endcase
          end
        end
        ST_CRC: begin
          if (crc_stat.last_step) begin
            state <= ST_IDLE;
          end
        end
        ST_DRAIN_RD: begin
          state <= ST_DRAIN_WR;
        end
        ST_DRAIN_WR: begin
          if (out_load) begin
            drain_idx <= drain_idx + 6'd1;
            state     <= drain_last ? ST_IDLE : ST_DRAIN_RD;
          end
        end
        ST_EMPTY: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (phase == PH_CMD)) begin
      cmd_reg <= rx_byte;
    end
    if (in_acc && (phase == PH_LENH)) begin
      len_hi <= rx_byte;
    end
    if (in_acc && (phase == PH_LENL)) begin
      length_reg <= len16[6:0];
    end
    if (out_load) begin
      frame_cmd    <= cmd_reg;
      frame_length <= length_reg;
      byte_index   <= (state == ST_DRAIN_WR) ? drain_idx : 6'd0;
      payload_byte <= (state == ST_DRAIN_WR) ? rd_data : 8'd0;
      has_data     <= (state == ST_DRAIN_WR);
      last         <= (state == ST_DRAIN_WR) ? drain_last : 1'b1;
    end
  end

  top_crc_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC) |-> crc_stat.busy)
    else $error("Sequencer waits on the CRC unit while it is idle");

  top_data_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> ((fill_index < length_reg) && (length_reg <= MaxLen)))
    else $error("Payload fill index or length out of range");

  top_last_matches_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_data && last) |->
      (({1'b0, byte_index} + 7'd1) == frame_length))
    else $error("Final payload result does not match the frame length");

  top_empty_notice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_data) |-> ((frame_length == 7'd0) && (payload_byte == 8'd0) && last))
    else $error("Empty frame notice carries data");

endmodule

// ===== rtl/core/sfdc_crc_unit.sv =====
// Bit-serial CRC-16 unit: folds one byte into the running checksum, one bit a cycle.
// Depends on sfdc_pkg for the control and status structs and the CRC constants.
module sfdc_crc_unit (
  input  logic              clk,
  input  logic              rst,
  input  sfdc_pkg::crc_ctrl_t ctrl,
  output sfdc_pkg::crc_stat_t stat,
  output logic [15:0]       crc
);
  import sfdc_pkg::*;

  logic [15:0] crc_reg;
  logic [2:0]  step;
  logic        busy;
  logic [15:0] crc_shift;

  assign crc_shift = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ CrcPoly)
                                 : {crc_reg[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CrcInit;
      busy    <= 1'b0;
      step    <= 3'd0;
    end else if (ctrl.init) begin
      crc_reg <= CrcInit;
    end else if (ctrl.start) begin
      crc_reg <= crc_reg ^ {ctrl.data, 8'h00};
      busy    <= 1'b1;
      step    <= 3'd0;
    end else if (busy) begin
      crc_reg <= crc_shift;
      step    <= step + 3'd1;
      if (step == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy      = busy;
  assign stat.last_step = busy && (step == 3'd7);
  assign crc            = crc_reg;

  crc_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctrl.start)
    else $error("CRC unit started while a byte was still being folded in");

  crc_busy_ends_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && step == 3'd7 && !ctrl.init) |=> !busy)
    else $error("CRC unit stayed busy beyond eight steps");

  crc_step_zero_when_started: assert property (@(posedge clk) disable iff (rst)
    (ctrl.start && !ctrl.init) |=> (busy && step == 3'd0))
    else $error("CRC unit did not begin a fresh byte");

endmodule

// ===== rtl/core/sfdc_payload_buf.sv =====
// Payload buffer: one write port and one registered read port over the frame bytes.
// No package dependencies; depth and address width come from the top level.
module sfdc_payload_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
